>>> design/dra_pkg.sv
// Shared types and constants for the discounted return / advantage estimator.
// No dependencies; imported by every module of the block.
package dra_pkg;

	localparam int FACTOR_W   = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd2;

	localparam logic                MODE_RESET   = 1'b1;
	localparam logic [FACTOR_W-1:0] GAMMA_RESET  = 17'd64881;
	localparam logic [FACTOR_W-1:0] LAMBDA_RESET = 17'd62259;
	localparam logic [FACTOR_W-1:0] DECAY_RESET  = 17'd61636;

	localparam logic MODE_RETURNS   = 1'b0;
	localparam logic MODE_ADVANTAGE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [FACTOR_W-1:0] gamma;
		logic [FACTOR_W-1:0] decay;
	} cfg_t;

	function automatic logic [FACTOR_W-1:0] clip_factor(input logic [FACTOR_W-1:0] f);
		return (f > ONE_Q16) ? ONE_Q16 : f;
	endfunction

endpackage

>>> design/discounted_return_and_advantage.sv
// Discounted return / advantage estimator, steps fed in reverse time order.
// Input register then result register; throughput 1 word/cycle while m_axis_tready is high,
// set by the multiply-add loop through the running estimate.
// Factor writes reach the gamma*lambda product through the factor register, then the product register.
// Reset (arst_n low): running estimate and next value cleared, registers to defaults.
// Depends on dra_pkg, dra_cfg, dra_datapath.
module discounted_return_and_advantage #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [DATA_WIDTH-1:0] reward, [2*DATA_WIDTH-1:DATA_WIDTH] value_estimate, zero pad
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [DATA_WIDTH-1:0] estimate, zero pad
	output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// [0] saturated
	output logic                            m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dra_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dra_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int OW = ((DATA_WIDTH+7)/8)*8;

	cfg_t cfg;

	logic                valid_s1;
	logic signed [W-1:0] reward_s1;
	logic signed [W-1:0] value_s1;
	logic                final_s1;
	logic                valid_s2;
	logic        [W-1:0] estimate_s2;
	logic                sat_s2;
	logic signed [W-1:0] running_q;
	logic signed [W-1:0] next_value_q;
	logic                advance;
	logic        [W-1:0] estimate;
	logic                saturated;

	dra_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dra_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.cfg            (cfg),
		.reward         (reward_s1),
		.value_estimate (value_s1),
		.final_step     (final_s1),
		.running        (running_q),
		.next_value     (next_value_q),
		.estimate       (estimate),
		.saturated      (saturated)
	);

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			running_q    <= '0;
			next_value_q <= '0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance) begin
				valid_s2     <= 1'b1;
				running_q    <= estimate;
				next_value_q <= value_s1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			reward_s1 <= s_axis_tdata[W-1:0];
			value_s1  <= s_axis_tdata[2*W-1:W];
			final_s1  <= s_axis_tlast;
		end
		if (advance) begin
			estimate_s2 <= estimate;
			sat_s2      <= saturated;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OW'(estimate_s2);
	assign m_axis_tuser  = sat_s2;

endmodule

>>> design/dra_cfg.sv
// Configuration register file: mode, gamma, lambda, and the gamma*lambda product.
// Depends on dra_pkg.
module dra_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dra_pkg::CFG_DATA_W-1:0] cfg_data,
	output dra_pkg::cfg_t                  cfg
);
	import dra_pkg::*;

	logic                  mode_q;
	logic [FACTOR_W-1:0]   gamma_q;
	logic [FACTOR_W-1:0]   lambda_q;
	logic [FACTOR_W-1:0]   decay_q;
	logic [2*FACTOR_W-1:0] decay_prod;

	assign cfg_ready  = 1'b1;
	assign decay_prod = gamma_q * lambda_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			gamma_q  <= GAMMA_RESET;
			lambda_q <= LAMBDA_RESET;
			decay_q  <= DECAY_RESET;
		end else begin
			// product register follows the factors in the cycle after they change
			decay_q <= decay_prod[16+FACTOR_W-1:16];
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[0];
					REG_GAMMA:  gamma_q  <= clip_factor(cfg_data);
					REG_LAMBDA: lambda_q <= clip_factor(cfg_data);
					default: ;
				endcase
			end
		end
	end

	assign cfg.mode  = mode_q;
	assign cfg.gamma = gamma_q;
	assign cfg.decay = decay_q;

endmodule

>>> design/dra_datapath.sv
// Single-step estimator arithmetic: floored Q1.16 scaling, wide sums, final clamp.
// Depends on dra_pkg.
module dra_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  dra_pkg::cfg_t                 cfg,
	input  logic signed [DATA_WIDTH-1:0]  reward,
	input  logic signed [DATA_WIDTH-1:0]  value_estimate,
	input  logic                          final_step,
	input  logic signed [DATA_WIDTH-1:0]  running,
	input  logic signed [DATA_WIDTH-1:0]  next_value,
	output logic        [DATA_WIDTH-1:0]  estimate,
	output logic                          saturated
);
	import dra_pkg::*;

	localparam int  W      = DATA_WIDTH;
	localparam int  SW     = DATA_WIDTH + 2;
	localparam int  PW     = DATA_WIDTH + FACTOR_W + 1;
	localparam bit  CLIP64 = (SW > 64);
	localparam logic signed [SW-1:0] L64_HI = SW'(64'sh7FFF_FFFF_FFFF_FFFF);
	localparam logic signed [SW-1:0] L64_LO = SW'(64'sh8000_0000_0000_0000);
	localparam logic signed [SW-1:0] W_HI   = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] W_LO   = {3'b111, {(W-1){1'b0}}};

	logic signed [W-1:0]  run_eff;
	logic signed [W-1:0]  nv_eff;
	logic signed [PW-1:0] prod_nv;
	logic signed [PW-1:0] prod_run;
	logic signed [W-1:0]  scaled_nv;
	logic signed [W-1:0]  scaled_run;
	logic        [FACTOR_W-1:0] run_factor;
	logic signed [SW-1:0] reward_x;
	logic signed [SW-1:0] bootstrap;
	logic signed [SW-1:0] delta;
	logic signed [SW-1:0] base;
	logic signed [SW-1:0] total;

	// partial sums saturate at 64 bits when the data word is wider than 62 bits
	function automatic logic signed [SW-1:0] sat64(input logic signed [SW-1:0] x);
		if (CLIP64 && x > L64_HI)
			return L64_HI;
		if (CLIP64 && x < L64_LO)
			return L64_LO;
		return x;
	endfunction

	assign run_eff    = final_step ? '0 : running;
	assign nv_eff     = final_step ? '0 : next_value;
	assign run_factor = (cfg.mode == MODE_ADVANTAGE) ? cfg.decay : cfg.gamma;

	// floor(f * x / 2^16) never exceeds |x|, so W bits hold it
	assign prod_nv    = $signed({1'b0, cfg.gamma}) * nv_eff;
	assign prod_run   = $signed({1'b0, run_factor}) * run_eff;
	assign scaled_nv  = prod_nv[W+15:16];
	assign scaled_run = prod_run[W+15:16];

	assign reward_x  = SW'(reward);
	assign bootstrap = sat64(reward_x + SW'(scaled_nv));
	assign delta     = sat64(bootstrap - SW'(value_estimate));
	assign base      = (cfg.mode == MODE_ADVANTAGE) ? delta : reward_x;
	assign total     = sat64(base + SW'(scaled_run));

	always_comb begin
		saturated = 1'b0;
		estimate  = total[W-1:0];
		if (total > W_HI) begin
			estimate  = W_HI[W-1:0];
			saturated = 1'b1;
		end else if (total < W_LO) begin
			estimate  = W_LO[W-1:0];
			saturated = 1'b1;
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for discounted_return_and_advantage: streams trajectory steps,
// predicts each return/advantage word and checks it. Needs dra_pkg and the block's RTL.
module tb;
	import dra_pkg::*;

	localparam int DW              = 32;
	localparam int LATENCY         = 2;
	localparam int SETTLE          = 2 * LATENCY + 2;
	localparam int IDLE_PCT        = 23;
	localparam int RX_HOLD         = 300;
	localparam int QUIET_LIMIT     = 2000;
	localparam int RAND_PHASES     = 12;
	localparam int STEPS_PER_PHASE = 48;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [DW-1:0] W_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DW-1:0] W_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [DW-1:0] reward;
		logic signed [DW-1:0] critic;
		logic                 final_step;
	} step_t;

	typedef struct {
		logic signed [DW-1:0] estimate;
		logic                 saturated;
	} est_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [2*DW-1:0]       s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DW-1:0]         m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// settings and state as the block should hold them
	logic                mode_q   = MODE_RESET;
	logic [FACTOR_W-1:0] gamma_q  = GAMMA_RESET;
	logic [FACTOR_W-1:0] lambda_q = LAMBDA_RESET;
	logic [FACTOR_W-1:0] decay_q  = DECAY_RESET;
	longint              run_est  = 0;
	longint              next_val = 0;

	step_t pending_steps[$];
	est_t  expected_estimates[$];
	step_t step_on_bus;
	int    steps_queued = 0;
	int    steps_accepted = 0;
	int    failures = 0;
	int    quiet_cycles = 0;
	int    rx_hold_req = 0;
	int    rx_hold_seen = 0;
	int    rx_hold_left = 0;
	bit    steady = 1'b0;

	discounted_return_and_advantage #(.DATA_WIDTH(DW)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [FACTOR_W-1:0] to_unit(logic [FACTOR_W-1:0] f);
		return (f > ONE_Q16) ? ONE_Q16 : f;
	endfunction

	// floor(f * x / 2^16)
	function automatic longint floor_scale(logic [FACTOR_W-1:0] f, longint x);
		return (longint'(f) * x) >>> 16;
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MODE:   mode_q = data[0];
			REG_GAMMA:  gamma_q = data;
			REG_LAMBDA: lambda_q = data;
			default: ;
		endcase
		decay_q = FACTOR_W'((longint'(to_unit(gamma_q)) * longint'(to_unit(lambda_q))) >>> 16);
	endfunction

	function automatic est_t next_estimate(step_t s);
		longint r;
		longint v;
		longint acc;
		est_t   res;
		r = s.reward;
		v = s.critic;
		if (s.final_step) begin
			run_est = 0;
			next_val = 0;
		end
		if (mode_q == MODE_ADVANTAGE)
			acc = r + floor_scale(to_unit(gamma_q), next_val) - v + floor_scale(decay_q, run_est);
		else
			acc = r + floor_scale(to_unit(gamma_q), run_est);
		res.saturated = 1'b0;
		if (acc > longint'(W_MAX)) begin
			acc = W_MAX;
			res.saturated = 1'b1;
		end else if (acc < longint'(W_MIN)) begin
			acc = W_MIN;
			res.saturated = 1'b1;
		end
		run_est = acc;
		next_val = v;
		res.estimate = acc[DW-1:0];
		return res;
	endfunction

	function automatic logic [FACTOR_W-1:0] pick_factor();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ONE_Q16;
			2: return 17'h1FFFF;
			3: return FACTOR_W'($urandom_range(0, 17'h1FFFF));
			default: return FACTOR_W'($urandom_range(58000, 65536));
		endcase
	endfunction

	function automatic logic signed [DW-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return W_MAX;
			2: return W_MIN;
			default: return $signed(DW'($urandom_range(0, 32'h1F_FFFF))) - 32'sh10_0000;
		endcase
	endfunction

	task automatic queue_step(logic signed [DW-1:0] r, logic signed [DW-1:0] v, logic fin);
		step_t s;
		s.reward = r;
		s.critic = v;
		s.final_step = fin;
		pending_steps.push_back(s);
		steps_queued++;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (steps_accepted != steps_queued || expected_estimates.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_DATA_W-1:0] mode_word,
			logic [CFG_DATA_W-1:0] gamma_word,
			logic [CFG_DATA_W-1:0] lambda_word, bit touch_spare);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		int                    n;
		idx[0] = REG_MODE;   val[0] = mode_word;
		idx[1] = REG_GAMMA;  val[1] = gamma_word;
		idx[2] = REG_LAMBDA; val[2] = lambda_word;
		idx[3] = REG_SPARE;  val[3] = CFG_DATA_W'($urandom);
		n = touch_spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk);
			while (!cfg_ready);
			apply_write(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		repeat (SETTLE) @(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_estimates.push_back(next_estimate(step_on_bus));
				steps_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_steps.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					step_on_bus = pending_steps.pop_front();
					s_axis_tdata  <= {step_on_bus.critic, step_on_bus.reward};
					s_axis_tlast  <= step_on_bus.final_step;
					s_axis_tvalid <= 1'b1;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		est_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_estimates.size() == 0) begin
					$error("result word with none expected: estimate %0d", $signed(m_axis_tdata));
					failures++;
				end else begin
					want = expected_estimates.pop_front();
					if (m_axis_tdata !== want.estimate) begin
						$error("estimate: expected %0d, got %0d", want.estimate, $signed(m_axis_tdata));
						failures++;
					end
					if (m_axis_tuser !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated, m_axis_tuser);
						failures++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_hold_req != rx_hold_seen) begin
				rx_hold_seen = rx_hold_req;
				rx_hold_left = RX_HOLD;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int                    traj_left;
		logic [CFG_DATA_W-1:0] mode_word;
		logic                  fin;
		traj_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, advantage mode
		queue_step(W_MAX, W_MIN, 1'b1);
		queue_step(W_MIN, W_MAX, 1'b0);
		queue_step(32'sd0, 32'sd0, 1'b0);
		queue_step(-32'sd1, 32'sd1, 1'b0);
		queue_step(32'sd1, -32'sd1, 1'b0);
		queue_step(32'sh0001_0000, 32'sh0000_8000, 1'b1);
		queue_step(W_MAX, W_MAX, 1'b0);
		queue_step(W_MIN, W_MIN, 1'b0);
		queue_step($urandom, $urandom, 1'b0);
		queue_step(-32'sd1, -32'sd1, 1'b1);
		settle();

		// returns mode picked up mid-trajectory, gamma exactly one
		write_regs({16'hFFFF, MODE_RETURNS}, ONE_Q16, '0, 1'b0);
		queue_step(32'sh3FFF_FFFF, $urandom, 1'b0);
		queue_step(W_MAX, W_MIN, 1'b0);
		queue_step(W_MAX, 32'sd0, 1'b0);
		queue_step(W_MIN, W_MAX, 1'b1);
		queue_step(W_MIN, 32'sd0, 1'b0);
		queue_step(32'sd0, 32'sd0, 1'b0);
		settle();

		// factors above one
		write_regs({16'd0, MODE_ADVANTAGE}, 17'h1FFFF, 17'h1FFFF, 1'b0);
		queue_step(32'sd1000, -32'sd500, 1'b0);
		queue_step(-32'sd1, -32'sd1, 1'b0);
		queue_step(W_MAX, W_MIN, 1'b1);
		queue_step(32'sd0, 32'sd0, 1'b0);
		settle();

		write_regs({16'd0, MODE_ADVANTAGE}, '0, '0, 1'b1);
		queue_step(32'sh0002_0000, 32'sh0001_0000, 1'b1);
		queue_step(-32'sh0002_0000, 32'sh0001_0000, 1'b0);
		queue_step($urandom, $urandom, 1'b0);
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			mode_word = CFG_DATA_W'($urandom);
			if ($urandom_range(0, 3) != 0)
				mode_word = {16'd0, mode_word[0]};
			write_regs(mode_word, pick_factor(), pick_factor(), $urandom_range(0, 3) == 0);
			steady = (p == 1);
			for (int i = 0; i < STEPS_PER_PHASE; i++) begin
				if (traj_left == 0) begin
					fin = 1'b1;
					traj_left = $urandom_range(1, 24);
				end else
					fin = 1'b0;
				traj_left--;
				queue_step(pick_word(), pick_word(), fin);
			end
			if (p == 3)
				rx_hold_req++;
			settle();
		end

		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
